// File: design/rlmd_pkg.sv
// Shared types and constants for the run-list mapping decoder.
`timescale 1ns / 1ps

package rlmd_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LANES   = 8;   // bytes per 64-bit field
  localparam int unsigned TOTAL_W = 7;   // width of the run_total field
  localparam int unsigned NIB_W   = 4;

  localparam logic [NIB_W-1:0] IDX_SAT = 4'hF;  // field byte index saturates here

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef enum logic {
    KIND_RUN = 1'b0,
    KIND_END = 1'b1
  } kind_e;

  // One result record as it leaves the block.
  typedef struct packed {
    kind_e               kind;
    logic [WORD_W-1:0]   start;
    logic                sparse;
    logic [WORD_W-1:0]   clusters;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } rec_t;

  // Up to two records produced by one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

// File: design/rlmd_step.sv
// Parse state and per-byte decode step of the run-list mapping decoder.
`timescale 1ns / 1ps

module rlmd_step
  import rlmd_pkg::*;
#(
  parameter int unsigned MAX_RUNS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              last_byte_i,
  output push_t             push_o
);

  localparam int unsigned CNT_W = $clog2(MAX_RUNS + 1);

  phase_e             phase_q, phase_d;
  logic [NIB_W-1:0]   len_left_q, len_left_d;
  logic [NIB_W-1:0]   off_left_q, off_left_d;
  logic [NIB_W-1:0]   idx_q, idx_d;
  logic [WORD_W-1:0]  len_acc_q, len_acc_d;
  logic [WORD_W-1:0]  off_acc_q, off_acc_d;
  logic [WORD_W-1:0]  clus_q, clus_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               off_empty_q, off_empty_d;

  logic               run_done, stop;
  logic [NIB_W-1:0]   idx_next;
  logic [CNT_W-1:0]   cnt_new;
  rec_t               run_rec, end_rec;

  // OR a byte into the lane picked by the field byte index.
  function automatic logic [WORD_W-1:0] take_byte(input logic [WORD_W-1:0] acc,
                                                  input logic [NIB_W-1:0]  idx,
                                                  input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] res;
    res = acc;
    for (int j = 0; j < LANES; j++) begin
      if (idx == NIB_W'(j)) res[j*BYTE_W +: BYTE_W] = acc[j*BYTE_W +: BYTE_W] | b;
    end
    return res;
  endfunction

  // Fill all lanes from idx upward with ones (sign extension).
  function automatic logic [WORD_W-1:0] sign_fill(input logic [WORD_W-1:0] acc,
                                                  input logic [NIB_W-1:0]  idx);
    logic [WORD_W-1:0] res;
    res = acc;
    for (int j = 0; j < LANES; j++) begin
      if (NIB_W'(j) >= idx) res[j*BYTE_W +: BYTE_W] = '1;
    end
    return res;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    len_left_d  = len_left_q;
    off_left_d  = off_left_q;
    idx_d       = idx_q;
    len_acc_d   = len_acc_q;
    off_acc_d   = off_acc_q;
    clus_d      = clus_q;
    off_empty_d = off_empty_q;
    run_done    = 1'b0;
    stop        = 1'b0;
    idx_next    = (idx_q < IDX_SAT) ? idx_q + 1'b1 : idx_q;

    if (in_fire_i) begin
      case (phase_q)
        PH_HEADER: begin
          if (data_byte_i[NIB_W-1:0] == '0) begin
            stop = 1'b1;
          end else begin
            len_left_d  = data_byte_i[NIB_W-1:0];
            off_left_d  = data_byte_i[BYTE_W-1:NIB_W];
            off_empty_d = (data_byte_i[BYTE_W-1:NIB_W] == '0);
            idx_d       = '0;
            len_acc_d   = '0;
            off_acc_d   = '0;
            phase_d     = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          len_acc_d  = take_byte(len_acc_q, idx_q, data_byte_i);
          idx_d      = idx_next;
          len_left_d = (len_left_q != '0) ? len_left_q - 1'b1 : len_left_q;
          if (len_left_d == '0) begin
            if (off_left_q == '0) begin
              run_done = 1'b1;
            end else begin
              phase_d = PH_OFFSET;
              idx_d   = '0;
            end
          end
        end
        PH_OFFSET: begin
          off_acc_d  = take_byte(off_acc_q, idx_q, data_byte_i);
          idx_d      = idx_next;
          off_left_d = (off_left_q != '0) ? off_left_q - 1'b1 : off_left_q;
          if (off_left_d == '0) begin
            if (idx_next < NIB_W'(LANES) && data_byte_i[BYTE_W-1]) begin
              off_acc_d = sign_fill(off_acc_d, idx_next);
            end
            run_done = 1'b1;
          end
        end
        default: ;  // list already ended: bytes are dropped
      endcase
    end

    cnt_new = run_done ? cnt_q + 1'b1 : cnt_q;
    cnt_d   = cnt_new;

    if (run_done) begin
      if (!off_empty_d) clus_d = clus_q + off_acc_d;
      if (cnt_new >= CNT_W'(MAX_RUNS)) stop = 1'b1;
      else                             phase_d = PH_HEADER;
    end
    if (in_fire_i && last_byte_i && phase_q != PH_DONE) stop = 1'b1;
    if (stop) phase_d = PH_DONE;

    run_rec.kind     = KIND_RUN;
    run_rec.start    = off_empty_d ? '1 : clus_d;
    run_rec.sparse   = off_empty_d;
    run_rec.clusters = len_acc_d;
    run_rec.total    = TOTAL_W'(cnt_new);
    run_rec.last     = !stop;

    end_rec.kind     = KIND_END;
    end_rec.start    = '0;
    end_rec.sparse   = 1'b0;
    end_rec.clusters = '0;
    end_rec.total    = TOTAL_W'(cnt_new);
    end_rec.last     = 1'b1;

    push_o.rec1 = end_rec;
    if (run_done) begin
      push_o.cnt  = stop ? 2'd2 : 2'd1;
      push_o.rec0 = run_rec;
    end else begin
      push_o.cnt  = stop ? 2'd1 : 2'd0;
      push_o.rec0 = end_rec;
    end

    // End of buffer puts everything back to the reset state.
    if (in_fire_i && last_byte_i) begin
      phase_d     = PH_HEADER;
      len_left_d  = '0;
      off_left_d  = '0;
      idx_d       = '0;
      len_acc_d   = '0;
      off_acc_d   = '0;
      clus_d      = '0;
      cnt_d       = '0;
      off_empty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      len_left_q  <= '0;
      off_left_q  <= '0;
      idx_q       <= '0;
      len_acc_q   <= '0;
      off_acc_q   <= '0;
      clus_q      <= '0;
      cnt_q       <= '0;
      off_empty_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_left_q  <= len_left_d;
      off_left_q  <= off_left_d;
      idx_q       <= idx_d;
      len_acc_q   <= len_acc_d;
      off_acc_q   <= off_acc_d;
      clus_q      <= clus_d;
      cnt_q       <= cnt_d;
      off_empty_q <= off_empty_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RUNS))
    else $error("run counter above run limit");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt == 2'd2) |-> (push_o.rec0.kind == KIND_RUN && push_o.rec1.kind == KIND_END
                              && !push_o.rec0.last))
    else $error("two-record step must be run then end record");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && phase_q == PH_DONE && !last_byte_i) |=> (phase_q == PH_DONE))
    else $error("left ended state before end of buffer");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) |-> (push_o.cnt == 2'd0))
    else $error("record produced after end of list");

endmodule

// File: design/rlmd_out_queue.sv
// Three-entry result queue; takes up to two records per cycle, drains one per cycle while out_ready_i is high.
`timescale 1ns / 1ps

module rlmd_out_queue
  import rlmd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rec_t  head_o
);

  localparam int unsigned Q_DEPTH = 3;

  rec_t       slot_q [Q_DEPTH];
  rec_t       slot_d [Q_DEPTH];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign room_o      = (cnt_q <= 2'd1);
  assign head_o      = slot_q[0];

  always_comb begin
    pop  = out_valid_o && out_ready_i;
    base = cnt_q - {1'b0, pop};
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (pop && i < Q_DEPTH - 1) slot_d[i] = slot_q[(i + 1) % Q_DEPTH];
      else                        slot_d[i] = slot_q[i];
      if (push_i.cnt != 2'd0 && base == 2'(i))                  slot_d[i] = push_i.rec0;
      if (push_i.cnt == 2'd2 && base + 2'd1 == 2'(i))           slot_d[i] = push_i.rec1;
    end
    cnt_d = base + push_i.cnt;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Q_DEPTH; i++) slot_q[i] <= slot_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 2'd1) |-> (push_i.cnt == 2'd0))
    else $error("records pushed into a full queue");

endmodule

// File: design/run_list_mapping_decoder.sv
// Top level of the mapping-pairs run-list decoder.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// -------  ---------  ---------------------  ---------------------------------------------
// in       input      in_valid_i/in_ready_o  data_byte_i, last_byte_i
// out      output     out_valid_o/out_ready_i record_kind_o, cluster_start_o, sparse_run_o,
//                                             run_clusters_o, run_total_o, last_result_o
//
// One byte per cycle while in_ready_o is high: each accepted byte is decoded in the cycle
// of its transfer and its zero, one or two records are registered in a three-entry result
// queue. in_ready_o is high while the queue holds at most one record, so a byte that makes
// two records (run plus end record) holds off the next byte until the queue is back to at most one record.
// Reset (rst_ni low, async) puts the parser at the header phase with zero counters and
// empties the queue. A stall on the output only blocks input once two records are waiting.

module run_list_mapping_decoder
  import rlmd_pkg::*;
#(
  parameter int unsigned MAX_RUNS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     record_kind_o,
  output logic signed [63:0]       cluster_start_o,
  output logic                     sparse_run_o,
  output logic [63:0]              run_clusters_o,
  output logic [6:0]               run_total_o,
  output logic                     last_result_o
);

  push_t push;
  rec_t  head;
  logic  in_fire;

  // Byte transfer: the decode step only advances on a completed handshake.
  assign in_fire = in_valid_i && in_ready_o;

  rlmd_step #(
    .MAX_RUNS (MAX_RUNS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push)
  );

  // Result register stage: decouples output stalls from the byte stream.
  rlmd_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign record_kind_o   = head.kind;
  assign cluster_start_o = head.start;
  assign sparse_run_o    = head.sparse;
  assign run_clusters_o  = head.clusters;
  assign run_total_o     = head.total;
  assign last_result_o   = head.last;

endmodule

// File: test/run_list_mapping_decoder_tb.sv
// Self-checking testbench for the mapping-pairs run-list decoder.
`timescale 1ns / 1ps

module run_list_mapping_decoder_tb
  import rlmd_pkg::*;
();

  localparam int RUN_LIMIT   = 64;      // MAX_RUNS of the instance
  localparam int ITEM_TARGET = 1750;    // decoded (not ignored) bytes in the random part
  localparam int LONG_HOLD   = 300;     // receiver hold-off that fills the result queue
  localparam int CYCLE_LIMIT = 400000;  // watchdog
  localparam int DRAIN_WAIT  = 20;      // cycles after the last record

  typedef logic [7:0] byte_q_t[$];

  // --------------------------------------------------------------------------
  // Scoreboard: decodes every accepted byte on its own copy of the parser state,
  // queues the records it should cause, and checks records as they leave.
  // --------------------------------------------------------------------------
  class run_list_scoreboard;
    phase_e      phase;
    logic [3:0]  len_left;
    logic [3:0]  off_left;
    logic [3:0]  byte_idx;
    logic [63:0] len_acc;
    logic [63:0] off_acc;
    logic [63:0] cluster;
    logic [6:0]  runs;
    logic        no_offset;
    rec_t        record_q[$];
    int unsigned mismatches;
    int unsigned decoded_bytes;
    int unsigned records_seen;

    function new();
      clear_parser();
      mismatches    = 0;
      decoded_bytes = 0;
      records_seen  = 0;
    endfunction

    function void clear_parser();
      phase     = PH_HEADER;
      len_left  = '0;
      off_left  = '0;
      byte_idx  = '0;
      len_acc   = '0;
      off_acc   = '0;
      cluster   = '0;
      runs      = '0;
      no_offset = 1'b0;
    endfunction

    // Little-endian gather; bytes past the eighth only move the index.
    function logic [63:0] merge_byte(logic [63:0] acc, logic [7:0] b);
      logic [63:0] res;
      res = acc;
      if (byte_idx < 4'd8) res = acc | (64'(b) << (int'(byte_idx) * 8));
      if (byte_idx != IDX_SAT) byte_idx = byte_idx + 4'd1;
      return res;
    endfunction

    function rec_t make_rec(kind_e k, logic [63:0] st, logic sp, logic [63:0] cl);
      rec_t r;
      r.kind     = k;
      r.start    = st;
      r.sparse   = sp;
      r.clusters = cl;
      r.total    = runs;
      r.last     = 1'b0;
      return r;
    endfunction

    // Called once per input transfer.
    function void note_byte(logic [7:0] b, logic lst);
      rec_t recs[2];
      int   n;
      logic stop;
      logic run_done;
      stop     = 1'b0;
      run_done = 1'b0;
      n        = 0;
      if (phase == PH_DONE) begin
        // rest of the buffer is skipped; a flagged byte rearms the parser
        if (lst) clear_parser();
        return;
      end
      decoded_bytes++;
      case (phase)
        PH_HEADER: begin
          if (b[3:0] == 4'd0) begin
            stop = 1'b1;
          end else begin
            len_left  = b[3:0];
            off_left  = b[7:4];
            no_offset = (b[7:4] == 4'd0);
            byte_idx  = '0;
            len_acc   = '0;
            off_acc   = '0;
            phase     = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          len_acc = merge_byte(len_acc, b);
          if (len_left != 4'd0) len_left = len_left - 4'd1;
          if (len_left == 4'd0) begin
            if (off_left == 4'd0) begin
              run_done = 1'b1;
            end else begin
              phase    = PH_OFFSET;
              byte_idx = '0;
            end
          end
        end
        default: begin  // offset bytes
          off_acc = merge_byte(off_acc, b);
          if (off_left != 4'd0) off_left = off_left - 4'd1;
          if (off_left == 4'd0) begin
            // sign-extend short fields from bit 7 of the final byte
            if (byte_idx < 4'd8 && b[7]) off_acc = off_acc | ('1 << (int'(byte_idx) * 8));
            run_done = 1'b1;
          end
        end
      endcase

      if (run_done) begin
        runs = runs + 7'd1;
        if (no_offset) begin
          recs[n] = make_rec(KIND_RUN, '1, 1'b1, len_acc);
        end else begin
          cluster = cluster + off_acc;
          recs[n] = make_rec(KIND_RUN, cluster, 1'b0, len_acc);
        end
        n++;
        if (int'(runs) >= RUN_LIMIT) stop = 1'b1;
        else phase = PH_HEADER;
      end
      if (lst) stop = 1'b1;
      if (stop) begin
        recs[n] = make_rec(KIND_END, '0, 1'b0, '0);
        n++;
        phase = PH_DONE;
      end
      if (n > 0) recs[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) record_q.push_back(recs[i]);
      if (lst) clear_parser();
    endfunction

    function int pending();
      return record_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task cmp_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("record %0d %s: got %h, expected %h", records_seen, name, got, want));
    endtask

    // Called once per output transfer.
    task check_record(logic kind, logic [63:0] st, logic sp, logic [63:0] cl,
                      logic [6:0] tot, logic lst);
      rec_t want;
      if (record_q.size() == 0) begin
        report($sformatf("record %0d arrived with nothing outstanding", records_seen));
      end else begin
        want = record_q.pop_front();
        cmp_field("record_kind", 64'(kind), 64'(want.kind));
        cmp_field("cluster_start", st, want.start);
        cmp_field("sparse_run", 64'(sp), 64'(want.sparse));
        cmp_field("run_clusters", cl, want.clusters);
        cmp_field("run_total", 64'(tot), 64'(want.total));
        cmp_field("last_result", 64'(lst), 64'(want.last));
      end
      records_seen++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block hookup
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               last_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               record_kind_o;
  logic signed [63:0] cluster_start_o;
  logic               sparse_run_o;
  logic [63:0]        run_clusters_o;
  logic [6:0]         run_total_o;
  logic               last_result_o;

  run_list_mapping_decoder #(
    .MAX_RUNS(RUN_LIMIT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .record_kind_o  (record_kind_o),
    .cluster_start_o(cluster_start_o),
    .sparse_run_o   (sparse_run_o),
    .run_clusters_o (run_clusters_o),
    .run_total_o    (run_total_o),
    .last_result_o  (last_result_o)
  );

  run_list_scoreboard sb = new();

  bit hold_req   = 1'b0;  // raised by the stimulus to ask for the long hold-off
  int burst_left = 0;     // transfers left in the current sender burst
  int cycles     = 0;

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("run_list_mapping_decoder_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Called at a falling edge; payload changes only on falling edges.
  // Valid stays up between transfers of a burst; a gap drops it for a while.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lst;
    // in_ready_o read right at the edge is the value the transfer used
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, lst);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 60);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // One buffer: the flag goes on its final byte.
  task automatic send_stream(input byte_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Field bytes lean toward the extremes now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Field byte count: mostly short, sometimes full width, sometimes over-long.
  function automatic int pick_count(bit allow_zero);
    int r;
    r = $urandom_range(0, 19);
    if (allow_zero && r < 4) return 0;
    if (r < 14) return $urandom_range(1, 4);
    if (r < 18) return $urandom_range(5, 8);
    return $urandom_range(9, 15);
  endfunction

  function automatic byte_q_t make_run();
    byte_q_t s;
    int      len_n;
    int      off_n;
    len_n = pick_count(1'b0);
    off_n = pick_count(1'b1);  // zero offset bytes gives a sparse run
    s.push_back({4'(off_n), 4'(len_n)});
    repeat (len_n + off_n) s.push_back(pick_byte());
    return s;
  endfunction

  // Mostly well-formed run lists with random content and a random way of
  // ending; a few buffers of plain noise.
  task automatic send_random_buffer(input bit to_limit);
    byte_q_t stream;
    byte_q_t piece;
    int      n_runs;
    int      keep;
    if (!to_limit && $urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 30)) stream.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (to_limit || $urandom_range(0, 11) == 0)
        n_runs = RUN_LIMIT - 1 + $urandom_range(0, 3);
      else
        n_runs = $urandom_range(0, 8);
      repeat (n_runs) begin
        piece = make_run();
        foreach (piece[i]) stream.push_back(piece[i]);
      end
      case ($urandom_range(0, 4))
        0: begin  // zero header, then trailing bytes that must be skipped
          stream.push_back(8'h00);
          repeat ($urandom_range(0, 4)) stream.push_back(pick_byte());
        end
        1: begin  // offset count set but length count zero
          stream.push_back({4'($urandom_range(0, 15)), 4'h0});
          repeat ($urandom_range(0, 4)) stream.push_back(pick_byte());
        end
        2: begin  // buffer cut inside a run, possibly right at its header
          piece = make_run();
          keep  = $urandom_range(1, piece.size() - 1);
          for (int i = 0; i < keep; i++) stream.push_back(piece[i]);
        end
        3: ;      // buffer ends just after a complete run
        default: repeat ($urandom_range(1, 6)) stream.push_back(8'($urandom_range(0, 255)));
      endcase
      if (stream.size() == 0) stream.push_back(8'h00);
    end
    send_stream(stream);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: checks each output transfer at the rising edge, then picks
  // out_ready_i for the next cycle at the falling edge. Stall style changes
  // every so often; once, when the stimulus asks, it holds off for a stretch set by LONG_HOLD.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode;
    int mode_left;
    int period;
    int hold_left;
    int tick;
    out_ready_i = 1'b0;
    mode        = 0;
    mode_left   = 0;
    period      = 2;
    hold_left   = 0;
    tick        = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_record(record_kind_o, cluster_start_o, sparse_run_o, run_clusters_o,
                        run_total_o, last_result_o);
      @(negedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
          period    = $urandom_range(2, 7);
        end
        mode_left--;
        case (mode)
          0:       out_ready_i <= 1'b1;                          // no stalls
          1:       out_ready_i <= 1'($urandom_range(0, 1));      // coin toss
          2:       out_ready_i <= ((tick % period) != 0);        // periodic bubble
          default: out_ready_i <= ($urandom_range(0, 3) == 0);   // mostly stalled
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed buffers.
    // Negative one-byte offset off a zero base, a sparse zero-length run,
    // a zero header, a skipped byte and a flagged byte that is only skipped.
    send_stream('{8'h11, 8'hFF, 8'h80, 8'h01, 8'h00, 8'h00, 8'h55, 8'h21});
    // Three-byte offset with the sign bit set; flagged header with no length.
    send_stream('{8'h31, 8'h05, 8'h7F, 8'h00, 8'h80, 8'h10});
    // Buffer ends inside the offset field: partial run dropped.
    send_stream('{8'h21, 8'h01, 8'hFF});
    // Buffer ends right after a run: run record then end record.
    send_stream('{8'h01, 8'h09});
    // Buffer ends on a header byte.
    send_stream('{8'h07});

    // Random part. The first buffer carries at least RUN_LIMIT - 1 runs while the receiver
    // holds off, so the result queue fills and the input stalls.
    sb.decoded_bytes = 0;
    hold_req = 1'b1;
    send_random_buffer(1'b1);
    while (sb.decoded_bytes < ITEM_TARGET) send_random_buffer(1'b0);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("run_list_mapping_decoder_tb: done, clean");
    end else begin
      $display("run_list_mapping_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
